@@ hdl/ugti_pkg.sv @@
package ugti_pkg;

	// Fixed field widths.
	localparam int ARG_W   = 24;
	localparam int STEP_W  = 26;
	localparam int PROD_W  = ARG_W + STEP_W;
	localparam int LOC_W   = PROD_W - 32;
	localparam int FRAC_W  = 16;
	localparam int MAG_W   = 18;
	localparam int WORD_W  = 31;
	localparam int ACC_W   = 64;

	localparam int DEF_MAX_ROWS   = 16;
	localparam int DEF_MAX_POINTS = 1024;
	localparam int MIN_POINTS     = 4;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 26;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_POINTS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER_ROWS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_STEP = 2'd2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// ceil(2^33 / 3): floor(y / 3) == (y * DIV3_RECIP) >> 33 for any 32-bit y.
	localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;

	typedef struct packed {
		logic                op;
		logic [3:0]          order;
		logic [9:0]          column;
		logic [WORD_W-1:0]   table_word;
		logic [ARG_W-1:0]    argument;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               out_of_range;
	} out_item_t;

	typedef struct packed {
		logic [10:0]       grid_points;
		logic [4:0]        order_rows;
		logic [STEP_W-1:0] inverse_step;
	} cfg_t;

	typedef enum logic [1:0] {KIND_LEFT, KIND_RIGHT, KIND_MID} kind_t;

	typedef enum logic [2:0] {ND_M1, ND_Z, ND_P1, ND_P2, ND_ONE} node_t;

	typedef enum logic [1:0] {RND_SH2, RND_SH3, RND_SH19, RND_DIV3} rnd_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_CHECK, ST_ISSUE, ST_WAIT, ST_ROUND, ST_FIN
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       mul;
		logic       check;
		logic       issue;
		logic [1:0] tap;
		logic       rnd;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic oor;
		logic three_tap;
		logic busy;
		logic out_free;
	} dp_sts_t;

	typedef struct packed {
		node_t f0;
		node_t f1;
		node_t f2;
		rnd_t  rnd;
		logic  neg;
	} tap_desc_t;

	// Per tap: the nodes whose factors form the numerator, the rounding divisor
	// (denominator times 4 for three taps, times 2^18 for four), and the weight sign.
	// Every factor has a fixed sign inside a cell, so the sign is known up front.
	function automatic tap_desc_t tap_desc(kind_t kind, logic [1:0] tap);
		case ({kind, tap})
			{KIND_LEFT,  2'd0}: return '{ND_P1, ND_P2, ND_ONE, RND_SH3,  1'b0};
			{KIND_LEFT,  2'd1}: return '{ND_Z,  ND_P2, ND_ONE, RND_SH2,  1'b0};
			{KIND_LEFT,  2'd2}: return '{ND_Z,  ND_P1, ND_ONE, RND_SH3,  1'b1};
			{KIND_RIGHT, 2'd0}: return '{ND_Z,  ND_P1, ND_ONE, RND_SH3,  1'b1};
			{KIND_RIGHT, 2'd1}: return '{ND_M1, ND_P1, ND_ONE, RND_SH2,  1'b0};
			{KIND_RIGHT, 2'd2}: return '{ND_M1, ND_Z,  ND_ONE, RND_SH3,  1'b0};
			{KIND_MID,   2'd0}: return '{ND_Z,  ND_P1, ND_P2,  RND_DIV3, 1'b1};
			{KIND_MID,   2'd1}: return '{ND_M1, ND_P1, ND_P2,  RND_SH19, 1'b0};
			{KIND_MID,   2'd2}: return '{ND_M1, ND_Z,  ND_P2,  RND_SH19, 1'b0};
			{KIND_MID,   2'd3}: return '{ND_M1, ND_Z,  ND_P1,  RND_DIV3, 1'b1};
			default:            return '{ND_ONE, ND_ONE, ND_ONE, RND_SH2, 1'b0};
		endcase
	endfunction

	// Magnitude of (t - d) for node d, in units of the fraction LSB.
	function automatic logic [MAG_W-1:0] node_mag(node_t node, logic [FRAC_W-1:0] t);
		case (node)
			ND_M1:   return {2'b00, t} + 18'h1_0000;
			ND_Z:    return {2'b00, t};
			ND_P1:   return 18'h1_0000 - {2'b00, t};
			ND_P2:   return 18'h2_0000 - {2'b00, t};
			ND_ONE:  return 18'd1;
			default: return '0;
		endcase
	endfunction

endpackage

@@ hdl/ugti_ctrl.sv @@
module ugti_ctrl import ugti_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    op,
	output logic    in_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	state_t     state_q, state_d;
	logic [1:0] tap_q;
	logic       last_tap;

	assign last_tap = (tap_q == (sts.three_tap ? 2'd2 : 2'd3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.check) begin
				tap_q <= '0;
			end else if (cmd.issue) begin
				tap_q <= tap_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && op == OP_QUERY) state_d = ST_MUL;
			end
			ST_MUL:   state_d = ST_CHECK;
			ST_CHECK: state_d = sts.oor ? ST_FIN : ST_ISSUE;
			ST_ISSUE: begin
				if (last_tap) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (!sts.busy) state_d = ST_ROUND;
			end
			ST_ROUND: state_d = ST_FIN;
			ST_FIN: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid && (op == OP_QUERY);
		cmd.mul      = (state_q == ST_MUL);
		cmd.check    = (state_q == ST_CHECK);
		cmd.issue    = (state_q == ST_ISSUE);
		cmd.tap      = tap_q;
		cmd.rnd      = (state_q == ST_ROUND);
		cmd.out_load = (state_q == ST_FIN) && sts.out_free;
	end

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && sts.three_tap |-> cmd.tap != 2'd3)
		else $error("fourth tap issued on a three-point cell");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !sts.busy)
		else $error("ready while the weight pipeline still holds taps");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over an unread result");

	a_capture_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready)
		else $error("ready right after a query was captured");

endmodule

@@ hdl/ugti_dp.sv @@
module ugti_dp import ugti_pkg::*; #(
	parameter int MAX_ROWS   = DEF_MAX_ROWS,
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  logic      in_accept,
	input  cfg_t      cfg,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	output out_item_t out_data,
	output logic      out_valid,
	input  logic      out_ready
);

	localparam int COL_W  = $clog2(MAX_POINTS);
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int DEPTH  = MAX_ROWS * (2 ** COL_W);
	localparam logic [LOC_W-1:0] MAXP_L = LOC_W'(MAX_POINTS);
	localparam logic [LOC_W-1:0] MINP_L = LOC_W'(MIN_POINTS);
	localparam logic [7:0]       MAXR_L = 8'(MAX_ROWS);

	logic [WORD_W-1:0] mem [DEPTH];

	// Query capture and argument scaling.
	logic [3:0]        order_q;
	logic [ARG_W-1:0]  arg_q;
	logic [PROD_W-1:0] prod_q;

	// Cell decode.
	logic [LOC_W-1:0]  loc_c, gp_c, npts_c;
	logic [FRAC_W-1:0] t_c, t_q;
	logic [7:0]        nrows_c;
	logic              oor_c, oor_q;
	kind_t             kind_c, kind_q;
	logic [COL_W-1:0]  loc_q;

	// Tap issue.
	tap_desc_t         desc_c;
	logic [COL_W-1:0]  rd_col;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic              wr_en;

	// Weight pipeline.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [MAG_W-1:0]   m0_s1, m1_s1, m2_s1, m2_s2;
	rnd_t               rnd_s1, rnd_s2, rnd_s3;
	logic               neg_s1, neg_s2, neg_s3, neg_s4;
	logic [WORD_W-1:0]  word_s1, word_s2, word_s3, word_s4, word_s5;
	logic [2*MAG_W-1:0] p01_s2;
	logic [3*MAG_W-1:0] p_s3;
	logic [3*MAG_W:0]   rsum_c;
	logic [31:0]        y_c, y_s4, q_c;
	logic               div3_s4;
	logic [63:0]        recip_c;
	logic signed [32:0] w_c, w_s5;
	logic signed [64:0] pw_c;
	logic signed [ACC_W-1:0] pw_s6, acc_q;

	// Final rounding and saturation.
	logic [ACC_W-1:0] acc_mag_c, acc_sum_c;
	logic [33:0]      rmag_q, rneg_v;
	logic             rneg_q;
	logic [31:0]      sat_c;
	out_item_t        out_q;
	logic             out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			order_q <= in_data.order;
			arg_q   <= in_data.argument;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(arg_q) * PROD_W'(cfg.inverse_step);
		end
	end

	always_comb begin
		loc_c = prod_q[PROD_W-1:32];
		t_c   = prod_q[31:16];
		gp_c  = LOC_W'(cfg.grid_points);
		if (gp_c < MINP_L) begin
			npts_c = MINP_L;
		end else if (gp_c > MAXP_L) begin
			npts_c = MAXP_L;
		end else begin
			npts_c = gp_c;
		end
		nrows_c = ({3'd0, cfg.order_rows} > MAXR_L) ? MAXR_L : {3'd0, cfg.order_rows};
		oor_c   = ({4'd0, order_q} >= nrows_c) || (loc_c >= npts_c - LOC_W'(1));
		if (loc_c == '0) begin
			kind_c = KIND_LEFT;
		end else if (loc_c == npts_c - LOC_W'(2)) begin
			kind_c = KIND_RIGHT;
		end else begin
			kind_c = KIND_MID;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			oor_q  <= oor_c;
			kind_q <= kind_c;
			loc_q  <= loc_c[COL_W-1:0];
			t_q    <= t_c;
		end
	end

	assign desc_c  = tap_desc(kind_q, cmd.tap);
	assign rd_col  = loc_q + COL_W'(cmd.tap) - COL_W'(kind_q != KIND_LEFT);
	assign rd_addr = {ROW_W'(order_q), rd_col};
	assign wr_addr = {ROW_W'(in_data.order), COL_W'(in_data.column)};
	assign wr_en   = in_accept && (in_data.op == OP_LOAD)
		&& ({28'd0, in_data.order} < 32'(MAX_ROWS))
		&& ({22'd0, in_data.column} < 32'(MAX_POINTS));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= in_data.table_word;
		end
		if (cmd.issue) begin
			word_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Rounding of |numerator| by the tap's divisor, half away from zero.
	// The divide-by-six taps divide by 2^19 first and by three afterwards.
	always_comb begin
		case (rnd_s3)
			RND_SH2:  rsum_c = {1'b0, p_s3} + 55'd2;
			RND_SH3:  rsum_c = {1'b0, p_s3} + 55'd4;
			RND_SH19: rsum_c = {1'b0, p_s3} + 55'h4_0000;
			RND_DIV3: rsum_c = {1'b0, p_s3} + 55'hC_0000;
			default:  rsum_c = {1'b0, p_s3};
		endcase
		case (rnd_s3)
			RND_SH2:  y_c = rsum_c[33:2];
			RND_SH3:  y_c = rsum_c[34:3];
			default:  y_c = rsum_c[50:19];
		endcase
	end

	assign recip_c = 64'(y_s4) * 64'(DIV3_RECIP);
	assign q_c     = div3_s4 ? {1'b0, recip_c[63:33]} : y_s4;
	assign w_c     = neg_s4 ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
	assign pw_c    = 65'(w_s5) * 65'($signed({2'b00, word_s5}));

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			m0_s1  <= node_mag(desc_c.f0, t_q);
			m1_s1  <= node_mag(desc_c.f1, t_q);
			m2_s1  <= node_mag(desc_c.f2, t_q);
			rnd_s1 <= desc_c.rnd;
			neg_s1 <= desc_c.neg;
		end
		p01_s2  <= (2*MAG_W)'(m0_s1) * (2*MAG_W)'(m1_s1);
		m2_s2   <= m2_s1;
		rnd_s2  <= rnd_s1;
		neg_s2  <= neg_s1;
		word_s2 <= word_s1;
		p_s3    <= (3*MAG_W)'(p01_s2) * (3*MAG_W)'(m2_s2);
		rnd_s3  <= rnd_s2;
		neg_s3  <= neg_s2;
		word_s3 <= word_s2;
		y_s4    <= y_c;
		div3_s4 <= (rnd_s3 == RND_DIV3);
		neg_s4  <= neg_s3;
		word_s4 <= word_s3;
		w_s5    <= w_c;
		word_s5 <= word_s4;
		pw_s6   <= $signed(pw_c[ACC_W-1:0]);
		if (cmd.check) begin
			acc_q <= '0;
		end else if (v_s6) begin
			acc_q <= acc_q + pw_s6;
		end
	end

	// Q60 sum to Q30, half away from zero, then saturate to 32 bits.
	assign acc_mag_c = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign acc_sum_c = acc_mag_c + 64'h2000_0000;
	assign rneg_v    = 34'd0 - rmag_q;

	always_ff @(posedge clk) begin
		if (cmd.rnd) begin
			rmag_q <= acc_sum_c[63:30];
			rneg_q <= acc_q[ACC_W-1];
		end
	end

	always_comb begin
		if (rneg_q) begin
			sat_c = (rmag_q > 34'h8000_0000) ? 32'h8000_0000 : rneg_v[31:0];
		end else begin
			sat_c = (rmag_q > 34'h7FFF_FFFF) ? 32'h7FFF_FFFF : rmag_q[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.value        <= oor_q ? 32'sd0 : $signed(sat_c);
			out_q.out_of_range <= oor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_data      = out_q;
	assign out_valid     = out_valid_q;
	assign sts.oor       = oor_c;
	assign sts.three_tap = (kind_q != KIND_MID);
	assign sts.busy      = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

@@ hdl/uniform_grid_table_interpolator_core.sv @@
// Table interpolator on a uniform grid: load items (op 0) write one 31-bit word
// of the value table and return nothing; a query item (op 1) returns one
// Lagrange-interpolated Q2.30 value, three points in the first and last cell,
// four elsewhere. A query that is in range keeps in_ready low while it scales
// the argument, decodes the cell, reads one word per tap through the single
// read port of the table, waits for the weight pipeline (two factor multiplies,
// rounding, divide by three, weight times word, accumulate) to drain, rounds
// and saturates the sum and loads the result once the output register is
// free. An out-of-range query goes from the cell decode straight to loading
// the result. The result waits in an output register, so the next item is
// taken while it is still unread. Table entries are not cleared by reset; a
// query must only touch entries that were loaded.
module uniform_grid_table_interpolator_core import ugti_pkg::*; #(
	parameter int MAX_ROWS   = DEF_MAX_ROWS,
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_points  <= 11'd1024;
			cfg_q.order_rows   <= 5'd16;
			cfg_q.inverse_step <= 26'd1310720;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GRID_POINTS:  cfg_q.grid_points  <= cfg_data[10:0];
				CFG_ORDER_ROWS:   cfg_q.order_rows   <= cfg_data[4:0];
				CFG_INVERSE_STEP: cfg_q.inverse_step <= cfg_data;
				default: ;
			endcase
		end
	end

	ugti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (in_data.op),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ugti_dp #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.in_accept (in_valid && in_ready),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

@@ dv/ugti_checker.sv @@
module ugti_checker import ugti_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  drain_check,
	output int                    mismatch_count
);

	localparam int ROWS        = DEF_MAX_ROWS;
	localparam int POINTS      = DEF_MAX_POINTS;
	localparam int MAX_REPORTS = 30;

	logic [WORD_W-1:0] word_mem [ROWS*POINTS];
	cfg_t              regs;
	out_item_t         expected_values [$];
	out_item_t         expected;
	int                results_checked;
	bit                drain_done;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_REPORTS)
			$display("ugti_checker: %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Rounds x / d to nearest, halves away from zero; d is positive.
	function automatic longint div_nearest(longint x, longint d);
		longint q;
		q = ((x < 0) ? -x : x);
		q = (q + d / 2) / d;
		return (x < 0) ? -q : q;
	endfunction

	function automatic out_item_t lagrange_value(in_item_t item);
		out_item_t         res;
		longint            npts, nrows, cell_idx, t, acc, num, den, wgt, val, addr;
		logic [PROD_W-1:0] scaled;
		int                taps, base, shift, i, j;
		res = '0;
		npts = regs.grid_points;
		if (npts < MIN_POINTS) npts = MIN_POINTS;
		if (npts > POINTS) npts = POINTS;
		nrows = regs.order_rows;
		if (nrows > ROWS) nrows = ROWS;
		scaled = item.argument * regs.inverse_step;
		cell_idx = scaled >> 32;
		t = scaled[31:16];
		if (longint'(item.order) >= nrows || cell_idx >= npts - 1) begin
			res.out_of_range = 1'b1;
			return res;
		end
		// The first and last cells fall back to three nodes that stay inside the grid.
		if (cell_idx == 0) begin
			taps = 3;
			base = 0;
		end else if (cell_idx == npts - 2) begin
			taps = 3;
			base = -1;
		end else begin
			taps = 4;
			base = -1;
		end
		shift = (taps == 3) ? 2 : 18;
		acc = 0;
		for (i = 0; i < taps; i++) begin
			num = 1;
			den = 1;
			for (j = 0; j < taps; j++) begin
				if (j != i) begin
					num = num * (t - longint'(base + j) * 65536);
					den = den * (i - j);
				end
			end
			if (den < 0) begin
				num = -num;
				den = -den;
			end
			wgt = div_nearest(num, den << shift);
			addr = longint'(item.order) * POINTS + cell_idx + base + i;
			acc += wgt * longint'(word_mem[addr]);
		end
		val = div_nearest(acc, longint'(1) << 30);
		if (val > 64'sd2147483647) val = 64'sd2147483647;
		if (val < -64'sd2147483648) val = -64'sd2147483648;
		res.value = val[31:0];
		return res;
	endfunction

	// Results are checked before the new item is taken, so a result can never
	// be matched against a query accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.grid_points = 11'd1024;
			regs.order_rows = 5'd16;
			regs.inverse_step = 26'd1310720;
			expected_values.delete();
			mismatch_count = 0;
			results_checked = 0;
			drain_done = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GRID_POINTS:  regs.grid_points = cfg_data[10:0];
					CFG_ORDER_ROWS:   regs.order_rows = cfg_data[4:0];
					CFG_INVERSE_STEP: regs.inverse_step = cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_values.size() == 0) begin
					report_mismatch($sformatf("result with no query waiting: value %0d, flag %0b",
						out_data.value, out_data.out_of_range));
				end else begin
					expected = expected_values.pop_front();
					if (out_data.value !== expected.value)
						report_mismatch($sformatf("result %0d: value %0d, expected %0d",
							results_checked, out_data.value, expected.value));
					if (out_data.out_of_range !== expected.out_of_range)
						report_mismatch($sformatf("result %0d: out_of_range %0b, expected %0b",
							results_checked, out_data.out_of_range, expected.out_of_range));
				end
				results_checked++;
			end
			if (in_valid && in_ready) begin
				if (in_data.op == OP_QUERY)
					expected_values.push_back(lagrange_value(in_data));
				else
					word_mem[in_data.order * POINTS + in_data.column] = in_data.table_word;
			end
			if (drain_check && !drain_done) begin
				drain_done = 1'b1;
				if (expected_values.size() != 0)
					report_mismatch($sformatf("%0d results never arrived",
						expected_values.size()));
			end
		end
	end

endmodule

@@ dv/tb_top.sv @@
module tb_top import ugti_pkg::*;;

	localparam int ROWS         = DEF_MAX_ROWS;
	localparam int POINTS       = DEF_MAX_POINTS;
	localparam int LOAD_SETTLE  = 24;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 750;
	localparam int PHASE_ITEMS  = 60;
	localparam logic [WORD_W-1:0] WORD_ONE = 31'h4000_0000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_GRID_POINTS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  drain_check = 1'b0;
	int                    mismatch_count;

	// Stimulus-side copy of the settings, also used to keep queries on loaded words.
	bit                loaded [ROWS*POINTS];
	int                grid_eff, rows_eff;
	logic [STEP_W-1:0] step_now;

	int burst_left, items_sent, queries_sent, loads_sent, results_seen;
	int settings_used, idle_cycles;
	int recv_mode, recv_hold, recv_epoch;

	initial begin
		forever #1 clk = ~clk;
	end

	uniform_grid_table_interpolator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ugti_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.drain_check    (drain_check),
		.mismatch_count (mismatch_count)
	);

	always @(posedge clk) begin
		if (out_valid && out_ready) results_seen++;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top: no handshake for %0d cycles", IDLE_LIMIT);
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	// The receiver switches at random between never stalling,
	// short stalls and long stalls.
	always @(negedge clk) begin
		recv_epoch++;
		if (recv_epoch % 300 == 0) recv_mode = $urandom_range(0, 2);
		if (recv_hold > 0) begin
			out_ready <= 1'b0;
			recv_hold--;
		end else begin
			out_ready <= 1'b1;
			if (recv_mode != 0 && $urandom_range(0, 3) == 0)
				recv_hold = $urandom_range(1, (recv_mode == 1) ? 3 : 20);
		end
	end

	// Entered and left at a falling edge; valid stays high between items of a burst.
	task automatic send_item(input in_item_t item);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		if (item.op == OP_QUERY) queries_sent++;
		else loads_sent++;
		@(negedge clk);
	endtask

	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return WORD_ONE;
			default: return WORD_W'($urandom_range(0, 32'h4000_0000));
		endcase
	endfunction

	task automatic load_word(input int row, input int col, input logic [WORD_W-1:0] word);
		in_item_t item;
		item.op = OP_LOAD;
		item.order = 4'(row);
		item.column = 10'(col);
		item.table_word = word;
		item.argument = ARG_W'($urandom);
		loaded[row * POINTS + col] = 1'b1;
		send_item(item);
	endtask

	// Any node the query will read that has not been loaded yet is loaded first.
	task automatic query(input int row, input logic [ARG_W-1:0] arg);
		in_item_t          item;
		logic [PROD_W-1:0] scaled;
		longint            cell_idx, first, last, c;
		scaled = arg * step_now;
		cell_idx = scaled >> 32;
		if (row < rows_eff && cell_idx < grid_eff - 1) begin
			first = (cell_idx == 0) ? 0 : cell_idx - 1;
			if (cell_idx == 0) last = 2;
			else if (cell_idx == grid_eff - 2) last = grid_eff - 1;
			else last = cell_idx + 2;
			for (c = first; c <= last; c++)
				if (!loaded[row * POINTS + c]) load_word(row, int'(c), random_word());
		end
		item.op = OP_QUERY;
		item.order = 4'(row);
		item.column = 10'($urandom);
		item.table_word = WORD_W'($urandom);
		item.argument = arg;
		send_item(item);
	endtask

	// Mostly arguments inside the grid, some at its upper edge, some anywhere.
	function automatic logic [ARG_W-1:0] random_argument();
		longint span, edge_arg;
		if (step_now == 0) span = 64'hFF_FFFF;
		else span = ((longint'(grid_eff - 1) << 32) - 1) / step_now;
		if (span > 64'hFF_FFFF) span = 64'hFF_FFFF;
		case ($urandom_range(0, 9))
			0: return ARG_W'($urandom);
			1: begin
				edge_arg = span + $urandom_range(0, 3) - 1;
				if (edge_arg < 0) edge_arg = 0;
				if (edge_arg > 64'hFF_FFFF) edge_arg = 64'hFF_FFFF;
				return ARG_W'(edge_arg);
			end
			default: return ARG_W'($urandom_range(0, 32'(span)));
		endcase
	endfunction

	function automatic int random_row();
		if (rows_eff == 0 || (rows_eff < ROWS && $urandom_range(0, 6) == 0))
			return $urandom_range(rows_eff, ROWS - 1);
		return $urandom_range(0, rows_eff - 1);
	endfunction

	task automatic set_phase(input logic [CFG_DATA_W-1:0] grid, input logic [CFG_DATA_W-1:0] rows,
			input logic [CFG_DATA_W-1:0] step);
		logic [CFG_IDX_W-1:0]  idxs [3];
		logic [CFG_DATA_W-1:0] vals [3];
		int                    r;
		idxs = '{CFG_GRID_POINTS, CFG_ORDER_ROWS, CFG_INVERSE_STEP};
		vals = '{grid, rows, step};
		in_valid <= 1'b0;
		burst_left = 0;
		while (results_seen != queries_sent) @(negedge clk);
		// A trailing load item may still be in flight after the last result.
		repeat (LOAD_SETTLE) @(negedge clk);
		for (r = 0; r < 3; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[r];
			cfg_data <= vals[r];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		grid_eff = grid[10:0];
		if (grid_eff < MIN_POINTS) grid_eff = MIN_POINTS;
		if (grid_eff > POINTS) grid_eff = POINTS;
		rows_eff = rows[4:0];
		if (rows_eff > ROWS) rows_eff = ROWS;
		step_now = step[STEP_W-1:0];
		settings_used++;
	endtask

	task automatic random_item();
		int                row, n;
		logic [ARG_W-1:0] arg;
		case ($urandom_range(0, 9))
			0: load_word($urandom_range(0, ROWS - 1), $urandom_range(0, POINTS - 1), random_word());
			1: begin
				// A short walk up one row.
				row = random_row();
				arg = random_argument();
				for (n = $urandom_range(2, 5); n > 0; n--) begin
					query(row, arg);
					arg = arg + ARG_W'($urandom_range(0, 40000));
				end
			end
			default: query(random_row(), random_argument());
		endcase
	endtask

	initial begin
		int               phase, phase_end, goal;
		logic [10:0]      grid_val;
		logic [4:0]       rows_val;
		logic [STEP_W-1:0] step_val;
		logic [31:0]      junk;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		grid_eff = POINTS;
		rows_eff = ROWS;
		step_now = 26'd1310720;
		settings_used = 1;

		// Reset settings: twenty grid points per unit of u over 1024 points.
		load_word(0, 0, '0);
		load_word(0, 1, WORD_ONE);
		load_word(0, 2, random_word());
		query(0, 24'd0);
		query(0, 24'd3276);
		load_word(15, 1020, WORD_ONE);
		load_word(15, 1021, '0);
		load_word(15, 1022, WORD_ONE);
		load_word(15, 1023, 31'h2AAA_AAAA);
		query(15, 24'd3345613);
		query(15, 24'd3348890);
		query(15, 24'd3352166);
		query(15, 24'd3352167);
		query(15, 24'hFF_FFFF);
		query(7, random_argument());

		// Smallest grid and a single row.
		set_phase(26'd4, 26'd1, 26'h1_0000);
		query(0, 24'd0);
		query(0, 24'h1_8000);
		query(0, 24'h2_FFFF);
		query(0, 24'h3_0000);
		query(15, 24'h0_8000);

		goal = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < goal) begin
			case (phase)
				0: set_phase(26'd1024, 26'd16, 26'h3FF_FFFF);
				1: set_phase(26'd0, 26'd31, 26'd0);
				2: set_phase(26'd2047, 26'd0, 26'd1);
				default: begin
					case ($urandom_range(0, 7))
						0: grid_val = 11'($urandom_range(4, 7));
						1: grid_val = 11'($urandom_range(0, 3));
						2: grid_val = 11'($urandom_range(1025, 2047));
						3: grid_val = 11'd1024;
						4: grid_val = 11'($urandom_range(4, 1024));
						default: grid_val = 11'($urandom_range(4, 64));
					endcase
					case ($urandom_range(0, 7))
						0: rows_val = 5'd0;
						1: rows_val = 5'($urandom_range(17, 31));
						2: rows_val = 5'd16;
						default: rows_val = 5'($urandom_range(1, 16));
					endcase
					case ($urandom_range(0, 9))
						0: step_val = '0;
						1: step_val = 26'h3FF_FFFF;
						default: step_val = STEP_W'($urandom_range(1, 26'h3FF_FFFF)
							>> $urandom_range(0, 25));
					endcase
					junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
					set_phase({junk[14:0], grid_val}, {junk[20:0], rows_val}, step_val);
				end
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end && items_sent < goal) random_item();
			phase++;
		end

		in_valid <= 1'b0;
		while (results_seen != queries_sent) @(negedge clk);
		repeat (LOAD_SETTLE) @(negedge clk);
		drain_check <= 1'b1;
		@(negedge clk);
		$display("tb_top: %0d items taken (%0d queries, %0d table loads), %0d results compared",
			items_sent, queries_sent, loads_sent, results_seen);
		$display("tb_top: %0d register settings, clamped sizes and zero step among them",
			settings_used);
		if (mismatch_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
